// ===== sv/nts_pkg.sv =====
// Shared constants, codes and beat types of the nearest texel sampler.
package nts_pkg;

  localparam int TEX_BYTES       = 262144;
  localparam int COORD_FRAC_BITS = 16;
  localparam int MAX_DIM         = 4096;

  localparam int ADDR_W     = $clog2(TEX_BYTES);
  localparam int DIM_W      = 13;
  localparam int CH_W       = 3;
  localparam int COORD_W    = 32;
  localparam int BYTE_W     = 8;
  localparam int COL_W      = 16;
  localparam int POS_W      = $clog2(MAX_DIM);
  localparam int LIN_W      = 2 * POS_W;
  localparam int IDX_W      = LIN_W + CH_W;

  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = $clog2(NUM_BANKS);
  localparam int ROW_W      = ADDR_W - BANK_SEL_W;
  localparam int BANK_DEPTH = TEX_BYTES / NUM_BANKS;
  localparam int TEXEL_B    = 3;

  localparam int BOOST_NUM   = 67502;
  localparam int BOOST_W     = 17;
  localparam int BOOST_LIMIT = 200;
  localparam int BOOST_SHIFT = 8;

  typedef enum logic [1:0] {
    CFG_TEX_WIDTH    = 2'd0,
    CFG_TEX_HEIGHT   = 2'd1,
    CFG_TEX_CHANNELS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic [ADDR_W-1:0]          load_address;
    logic [BYTE_W-1:0]          load_byte;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;
  } in_beat_t;

  typedef struct packed {
    logic [COL_W-1:0] red_out;
    logic [COL_W-1:0] green_out;
    logic [COL_W-1:0] blue_out;
    logic             unsupported_flag;
    logic             fault_flag;
  } out_beat_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

// ===== sv/nearest_texel_sampler_top.sv =====
// Nearest texel sampler with wrap addressing: top level with address pipeline and output stage.
// Takes one beat per cycle, loads and samples alike, with no stall of its own, while the output is not
// held off by out_ready_i. A sample passes through registered steps in order: fraction times span,
// row times width plus column, scaling by the channel count, the bound check and texel memory read,
// and the boost into the output register. The memory is split into four byte banks by the low
// address bits, so the three bytes of a texel come out of one read whatever their alignment. Loads
// write the memory in pipeline order, so a sample sees every load accepted before it. Loads give no
// result beat. The texel memory is not cleared: bytes read before they are loaded are undefined.
module nearest_texel_sampler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  nts_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output nts_pkg::out_beat_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [nts_pkg::DIM_W-1:0]    cfg_data_i
);
  import nts_pkg::*;

  logic [DIM_W-1:0] tex_w_q, tex_h_q;
  logic [CH_W-1:0]  tex_ch_q;

  logic             v1_q, v2_q, v3_q, v4_q, vo_q;
  logic             o_free, r1, r2, r3, r4;
  logic             go1, go2, go3, go4, en_in;

  kind_e             kind1_q, kind2_q, kind3_q;
  logic [ADDR_W-1:0] addr1_q, addr2_q, addr3_q;
  logic [BYTE_W-1:0] byte1_q, byte2_q, byte3_q;
  logic [POS_W-1:0]  x1_q, y1_q;
  logic [LIN_W-1:0]  lin2_q;
  logic [IDX_W-1:0]  idx3_q;
  logic              fault4_q, unsup4_q, grey4_q;
  out_beat_t         out_q;

  logic [DIM_W-1:0]               w_sat, h_sat;
  logic [POS_W-1:0]               span_w, span_h;
  logic [COORD_FRAC_BITS+POS_W-1:0] prod_u, prod_v;
  logic [IDX_W:0]                 idx_end;
  logic                           fault3, unsup3, grey3;

  wr_req_t                            wr_req;
  rd_req_t                            rd_req;
  logic [TEXEL_B-1:0][BYTE_W-1:0]     rd_data;
  logic [BYTE_W-1:0]                  c0, c1, c2;
  logic                               boost;
  out_beat_t                          out_d;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q  <= DIM_W'(1);
      tex_h_q  <= DIM_W'(1);
      tex_ch_q <= CH_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEX_WIDTH:    tex_w_q  <= cfg_data_i;
        CFG_TEX_HEIGHT:   tex_h_q  <= cfg_data_i;
        CFG_TEX_CHANNELS: tex_ch_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign o_free     = !vo_q || out_ready_i;
  assign go4        = v4_q && o_free;
  assign r4         = !v4_q || o_free;
  assign go3        = v3_q && ((kind3_q == KIND_LOAD) || r4);
  assign r3         = !v3_q || (kind3_q == KIND_LOAD) || r4;
  assign go2        = v2_q && r3;
  assign r2         = !v2_q || r3;
  assign go1        = v1_q && r2;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;
  assign en_in      = in_valid_i && r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_in)    v1_q <= 1'b1;
      else if (go1) v1_q <= 1'b0;
      if (go1)      v2_q <= 1'b1;
      else if (go2) v2_q <= 1'b0;
      if (go2)      v3_q <= 1'b1;
      else if (go3) v3_q <= 1'b0;
      if (go3 && (kind3_q == KIND_SAMPLE)) v4_q <= 1'b1;
      else if (go4)                        v4_q <= 1'b0;
      if (go4)              vo_q <= 1'b1;
      else if (out_ready_i) vo_q <= 1'b0;
    end
  end

  // stage 1: wrap and scale coordinates
  assign w_sat  = (tex_w_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_w_q;
  assign h_sat  = (tex_h_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_h_q;
  assign span_w = (w_sat == '0) ? '0 : POS_W'(w_sat - DIM_W'(1));
  assign span_h = (h_sat == '0) ? '0 : POS_W'(h_sat - DIM_W'(1));
  assign prod_u = (COORD_FRAC_BITS+POS_W)'(in_data_i.coord_u[COORD_FRAC_BITS-1:0])
                * (COORD_FRAC_BITS+POS_W)'(span_w);
  assign prod_v = (COORD_FRAC_BITS+POS_W)'(in_data_i.coord_v[COORD_FRAC_BITS-1:0])
                * (COORD_FRAC_BITS+POS_W)'(span_h);

  always_ff @(posedge clk_i) begin
    if (en_in) begin
      kind1_q <= in_data_i.kind;
      addr1_q <= in_data_i.load_address;
      byte1_q <= in_data_i.load_byte;
      x1_q    <= prod_u[COORD_FRAC_BITS+POS_W-1:COORD_FRAC_BITS];
      y1_q    <= prod_v[COORD_FRAC_BITS+POS_W-1:COORD_FRAC_BITS];
    end
    if (go1) begin
      kind2_q <= kind1_q;
      addr2_q <= addr1_q;
      byte2_q <= byte1_q;
      lin2_q  <= LIN_W'(y1_q) * LIN_W'(w_sat) + LIN_W'(x1_q);
    end
    if (go2) begin
      kind3_q <= kind2_q;
      addr3_q <= addr2_q;
      byte3_q <= byte2_q;
      idx3_q  <= IDX_W'(lin2_q) * IDX_W'(tex_ch_q);
    end
    if (go3 && (kind3_q == KIND_SAMPLE)) begin
      fault4_q <= fault3;
      unsup4_q <= unsup3;
      grey4_q  <= grey3;
    end
  end

  // stage 3: bound check and memory access
  assign grey3   = (tex_ch_q == CH_W'(1));
  assign unsup3  = (tex_ch_q == CH_W'(0)) || (tex_ch_q == CH_W'(2));
  assign idx_end = (IDX_W+1)'(idx3_q) + (grey3 ? (IDX_W+1)'(1) : (IDX_W+1)'(TEXEL_B));
  assign fault3  = idx_end > (IDX_W+1)'(TEX_BYTES);

  assign wr_req.en   = go3 && (kind3_q == KIND_LOAD) && (32'(addr3_q) < TEX_BYTES);
  assign wr_req.addr = addr3_q;
  assign wr_req.data = byte3_q;
  assign rd_req.en   = go3 && (kind3_q == KIND_SAMPLE);
  assign rd_req.addr = idx3_q[ADDR_W-1:0];

  nts_texmem u_texmem (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_i      (rd_req),
    .rd_data_o (rd_data)
  );

  // stage 4: color, boost
  assign c0    = rd_data[0];
  assign c1    = grey4_q ? rd_data[0] : rd_data[1];
  assign c2    = grey4_q ? rd_data[0] : rd_data[2];
  assign boost = (c0 < BYTE_W'(BOOST_LIMIT)) && (c1 < BYTE_W'(BOOST_LIMIT))
              && (c2 < BYTE_W'(BOOST_LIMIT));

  function automatic logic [COL_W-1:0] scale_col(logic [BYTE_W-1:0] c, logic bst);
    logic [BYTE_W+BOOST_W-1:0] p;
    p = (BYTE_W+BOOST_W)'(c) * (BYTE_W+BOOST_W)'(BOOST_NUM);
    return bst ? p[COL_W+BOOST_SHIFT-1:BOOST_SHIFT] : {c, BOOST_SHIFT'(0)};
  endfunction

  always_comb begin
    out_d = '0;
    if (unsup4_q) begin
      out_d.unsupported_flag = 1'b1;
    end else if (fault4_q) begin
      out_d.fault_flag = 1'b1;
    end else begin
      out_d.red_out   = scale_col(c0, boost);
      out_d.green_out = scale_col(c1, boost);
      out_d.blue_out  = scale_col(c2, boost);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go4) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.unsupported_flag && out_data_o.fault_flag))
    else $error("both result flags set");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.unsupported_flag || out_data_o.fault_flag)
    |-> (out_data_o.red_out == '0) && (out_data_o.green_out == '0)
        && (out_data_o.blue_out == '0))
    else $error("flagged result carries color");

  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && vo_q && !out_ready_i |=> v4_q && !$past(rd_req.en))
    else $error("read stage lost or overwritten under stall");

  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req.en |-> !wr_req.en && r4)
    else $error("read issued with write or without room");

endmodule

// ===== sv/nts_texmem.sv =====
// Four-way byte-banked texel memory: one byte write, one three-byte read per cycle.
module nts_texmem (
  input  logic                                            clk_i,
  input  nts_pkg::wr_req_t                                wr_i,
  input  nts_pkg::rd_req_t                                rd_i,
  output logic [nts_pkg::TEXEL_B-1:0][nts_pkg::BYTE_W-1:0] rd_data_o
);
  import nts_pkg::*;

  logic [BYTE_W-1:0]     bank_rd [NUM_BANKS];
  logic [BANK_SEL_W-1:0] off_q;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [BYTE_W-1:0]     mem [BANK_DEPTH];
    logic [BYTE_W-1:0]     rdata_q;
    logic [BANK_SEL_W-1:0] off;
    logic [ADDR_W-1:0]     addr;

    assign off  = BANK_SEL_W'(b) - rd_i.addr[BANK_SEL_W-1:0];
    assign addr = rd_i.addr + ADDR_W'(off);

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.addr[BANK_SEL_W-1:0] == BANK_SEL_W'(b))) begin
        mem[wr_i.addr[ADDR_W-1:BANK_SEL_W]] <= wr_i.data;
      end
      if (rd_i.en) begin
        rdata_q <= mem[addr[ADDR_W-1:BANK_SEL_W]];
      end
    end

    assign bank_rd[b] = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      off_q <= rd_i.addr[BANK_SEL_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < TEXEL_B; k++) begin
      rd_data_o[k] = bank_rd[off_q + BANK_SEL_W'(k)];
    end
  end

endmodule

// ===== tb/nearest_texel_sampler_checker.sv =====
// Checker for the nearest texel sampler: tracks loads and registers, predicts colors, compares.
`timescale 1ns / 100ps

module nearest_texel_sampler_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  nts_pkg::in_beat_t         in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  nts_pkg::out_beat_t        out_data_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [nts_pkg::DIM_W-1:0] cfg_data_i,
  output int                        mismatch_cnt_o,
  output int                        pending_o
);
  import nts_pkg::*;

  logic [BYTE_W-1:0] texels [TEX_BYTES];
  out_beat_t         colors_due_q [$];
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [CH_W-1:0]   chan_q;

  function automatic longint unsigned grid_pos(input logic [COORD_FRAC_BITS-1:0] frac,
                                               input longint unsigned dim);
    longint unsigned span;
    span = (dim == 0) ? 0 : dim - 1;
    return (frac * span) >> COORD_FRAC_BITS;
  endfunction

  function automatic logic [COL_W-1:0] scale_color(input logic [BYTE_W-1:0] c, input logic boost);
    longint unsigned t;
    t = boost ? (c * BOOST_NUM) >> BOOST_SHIFT : c << BOOST_SHIFT;
    return t[COL_W-1:0];
  endfunction

  function automatic out_beat_t predict_color(input logic [COORD_W-1:0] u, v);
    out_beat_t         res;
    longint unsigned   w, h, base;
    logic [BYTE_W-1:0] c0, c1, c2;
    logic              boost;
    res = '0;
    if (chan_q != 3'd1 && chan_q < 3'd3) begin
      res.unsupported_flag = 1'b1;
      return res;
    end
    w = (width_q > MAX_DIM) ? MAX_DIM : width_q;
    h = (height_q > MAX_DIM) ? MAX_DIM : height_q;
    base = (grid_pos(v[COORD_FRAC_BITS-1:0], h) * w + grid_pos(u[COORD_FRAC_BITS-1:0], w))
           * chan_q;
    if (base + ((chan_q >= 3'd3) ? 3 : 1) > TEX_BYTES) begin
      res.fault_flag = 1'b1;
      return res;
    end
    c0 = texels[base];
    if (chan_q >= 3'd3) begin
      c1 = texels[base + 1];
      c2 = texels[base + 2];
    end else begin
      c1 = c0;
      c2 = c0;
    end
    boost = (c0 < BOOST_LIMIT) && (c1 < BOOST_LIMIT) && (c2 < BOOST_LIMIT);
    res.red_out   = scale_color(c0, boost);
    res.green_out = scale_color(c1, boost);
    res.blue_out  = scale_color(c2, boost);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [COL_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      width_q  = 13'd1;
      height_q = 13'd1;
      chan_q   = 3'd3;
      colors_due_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (colors_due_q.size() == 0) begin
          $error("result beat with no sample outstanding");
          mismatch_cnt_o++;
        end else begin
          want = colors_due_q.pop_front();
          check_field("red_out", want.red_out, out_data_i.red_out);
          check_field("green_out", want.green_out, out_data_i.green_out);
          check_field("blue_out", want.blue_out, out_data_i.blue_out);
          check_field("unsupported_flag", COL_W'(want.unsupported_flag),
                      COL_W'(out_data_i.unsupported_flag));
          check_field("fault_flag", COL_W'(want.fault_flag), COL_W'(out_data_i.fault_flag));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == KIND_LOAD) begin
          texels[in_data_i.load_address] = in_data_i.load_byte;
        end else begin
          colors_due_q.push_back(predict_color(in_data_i.coord_u, in_data_i.coord_v));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEX_WIDTH: begin
            width_q = cfg_data_i;
          end
          CFG_TEX_HEIGHT: begin
            height_q = cfg_data_i;
          end
          CFG_TEX_CHANNELS: begin
            chan_q = cfg_data_i[CH_W-1:0];
          end
          default: ;
        endcase
      end
    end
    pending_o = colors_due_q.size();
  end

endmodule

// ===== tb/nearest_texel_sampler_top_tb.sv =====
// Testbench top for the nearest texel sampler: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 100ps

module nearest_texel_sampler_top_tb;
  import nts_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 85;

  localparam int PH_W [NUM_PHASES] = '{4, 7, 16, 3, 8191, 0, 5, 4096, 10, 6, 5, 9};
  localparam int PH_H [NUM_PHASES] = '{4, 5, 16, 9, 8191, 6, 0, 64, 7, 3, 5, 4};
  localparam int PH_C [NUM_PHASES] = '{3, 1, 3, 3, 3, 3, 1, 1, 4, 2, 7, 6};

  typedef enum int {
    PACE_NONE,
    PACE_TX,
    PACE_RX,
    PACE_BOTH
  } pace_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_beat_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_beat_t         out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_idx_i   = CFG_TEX_WIDTH;
  logic [DIM_W-1:0]  cfg_data_i  = '0;

  int                err_cnt;
  int                pending;
  int unsigned       item_cnt    = 0;
  int unsigned       quiet_cnt   = 0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_stall_pct = 0;
  bit                hold_go     = 1'b0;
  bit                loaded [TEX_BYTES];
  logic [DIM_W-1:0]  cur_w       = 13'd1;
  logic [DIM_W-1:0]  cur_h       = 13'd1;
  logic [CH_W-1:0]   cur_ch      = 3'd3;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  nearest_texel_sampler_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  nearest_texel_sampler_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (err_cnt),
    .pending_o      (pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint unsigned grid_pos(input logic [COORD_FRAC_BITS-1:0] frac,
                                               input longint unsigned dim);
    longint unsigned span;
    span = (dim == 0) ? 0 : dim - 1;
    return (frac * span) >> COORD_FRAC_BITS;
  endfunction

  // true when the sample reads texel bytes; base and count of those bytes
  function automatic bit texel_span(input logic [COORD_W-1:0] u, v,
                                    output longint unsigned base, output int unsigned nbytes);
    longint unsigned w, h;
    w = (cur_w > MAX_DIM) ? MAX_DIM : cur_w;
    h = (cur_h > MAX_DIM) ? MAX_DIM : cur_h;
    nbytes = (cur_ch >= 3'd3) ? 3 : 1;
    base = (grid_pos(v[COORD_FRAC_BITS-1:0], h) * w + grid_pos(u[COORD_FRAC_BITS-1:0], w))
           * cur_ch;
    return (cur_ch == 3'd1 || cur_ch >= 3'd3) && (base + nbytes <= TEX_BYTES);
  endfunction

  function automatic in_beat_t noise_beat();
    in_beat_t b;
    b.kind         = KIND_LOAD;
    b.load_address = ADDR_W'($urandom);
    b.load_byte    = BYTE_W'($urandom);
    b.coord_u      = $urandom;
    b.coord_v      = $urandom;
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    return BYTE_W'($urandom_range(1) ? $urandom_range(BOOST_LIMIT - 1) : $urandom_range(255));
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    c = $urandom;
    case ($urandom_range(9))
      0: c[COORD_FRAC_BITS-1:0] = '0;
      1: c[COORD_FRAC_BITS-1:0] = '1;
      default: ;
    endcase
    return c;
  endfunction

  function automatic void set_pace(input pace_e mode);
    tx_idle_pct  = (mode == PACE_TX) ? 49 : (mode == PACE_BOTH) ? 29 : 0;
    rx_stall_pct = (mode == PACE_RX) ? 49 : (mode == PACE_BOTH) ? 29 : 0;
  endfunction

  task automatic send_beat(input in_beat_t beat);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (beat.kind == KIND_LOAD) loaded[beat.load_address] = 1'b1;
    item_cnt++;
  endtask

  task automatic load_texel_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] val);
    in_beat_t b;
    b = noise_beat();
    b.load_address = addr;
    b.load_byte    = val;
    send_beat(b);
  endtask

  // fills any byte the sample would read that was never loaded, then samples
  task automatic sample_at(input logic [COORD_W-1:0] u, v);
    longint unsigned base;
    int unsigned     nbytes;
    in_beat_t        b;
    if (texel_span(u, v, base, nbytes)) begin
      for (int unsigned k = 0; k < nbytes; k++) begin
        if (!loaded[base + k]) load_texel_byte(ADDR_W'(base + k), pick_byte());
      end
    end
    b = noise_beat();
    b.kind    = KIND_SAMPLE;
    b.coord_u = u;
    b.coord_v = v;
    send_beat(b);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DIM_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_texture(input logic [DIM_W-1:0] w, h, input logic [CH_W-1:0] ch);
    logic [DIM_W-1:0] ch_word;
    ch_word = DIM_W'($urandom);
    ch_word[CH_W-1:0] = ch;
    wait_drained();
    write_reg(CFG_TEX_WIDTH, w);
    write_reg(CFG_TEX_HEIGHT, h);
    write_reg(CFG_TEX_CHANNELS, ch_word);
    cfg_we_i <= 1'b0;
    cur_w  = w;
    cur_h  = h;
    cur_ch = ch;
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      load_texel_byte(ADDR_W'($urandom), BYTE_W'($urandom));
    end else if (pick < 22) begin
      load_texel_byte(ADDR_W'($urandom_range(255)), pick_byte());
    end else begin
      sample_at(rand_coord(), rand_coord());
    end
  endtask

  initial begin
    int unsigned target;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;
    set_pace(PACE_NONE);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: 1x1 RGB; boost edge at 199/200
    load_texel_byte(18'd0, 8'd199);
    load_texel_byte(18'd1, 8'd0);
    load_texel_byte(18'd2, 8'd199);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'h8000_0000, 32'h7fff_ffff);
    load_texel_byte(18'd1, 8'd200);
    sample_at(32'hffff_ffff, 32'hffff_ffff);
    load_texel_byte(18'd2, 8'd255);
    load_texel_byte(18'd0, 8'd0);
    sample_at(32'h0001_0000, 32'hfffe_0000);
    load_texel_byte('1, 8'hff);

    // grey at full size: last row inside memory, then first row past it
    set_texture(13'd4096, 13'd4096, 3'd1);
    sample_at(32'h0000_ffff, {16'h8000, 16'd1009});
    sample_at(32'h0000_0000, {16'h0000, 16'd1025});
    sample_at(32'hdead_0000, 32'h0000_0000);

    set_texture(13'd1, 13'd1, 3'd0);
    sample_at(rand_coord(), rand_coord());
    set_texture(13'd1, 13'd1, 3'd2);
    sample_at(rand_coord(), rand_coord());

    // oversized dimensions saturate
    set_texture('1, '1, 3'd7);
    sample_at(32'h0000_ffff, 32'h0000_ffff);
    sample_at(32'h0000_0000, 32'h0000_0000);

    set_texture(13'd0, 13'd0, 3'd3);
    sample_at(rand_coord(), rand_coord());

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_texture(DIM_W'(PH_W[p]), DIM_W'(PH_H[p]), CH_W'(PH_C[p]));
      set_pace(pace_e'(p % 4));
      target = item_cnt + PHASE_ITEMS;
      while (item_cnt < target) begin
        if (p == 1 && !paused && item_cnt + 40 >= target) begin
          wait_drained();
          paused = 1'b1;
        end
        if (p == 2 && !held && item_cnt + 50 >= target) begin
          hold_go = 1'b1;
          held    = 1'b1;
        end
        random_item();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
